@@ design/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// lzss_pkg
// shared constants, token phase and event codes, and the control/status
// bundles between the lzss controller and datapath
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int BYTE_W          = 8;
    localparam int INDEX_BITS_DEF  = 13;
    localparam int LENGTH_BITS_DEF = 4;
    localparam int BREAK_EVEN_DIV  = 9;
    localparam int MAX_RESULTS     = 17;
    localparam int RES_CNT_W       = 5;
    localparam int BIT_CNT_W       = 4;

    // token phase
    localparam logic [1:0] PH_FLAG     = 2'd0;
    localparam logic [1:0] PH_LITERAL  = 2'd1;
    localparam logic [1:0] PH_POSITION = 2'd2;
    localparam logic [1:0] PH_LENGTH   = 2'd3;

    // what the current bit completes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_LITERAL = 2'd1;
    localparam logic [1:0] EV_ENDMARK = 2'd2;
    localparam logic [1:0] EV_MATCH   = 2'd3;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic bit_step;
        logic copy_rd;
        logic copy_wr;
        logic flush;
    } lzss_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       finished;
        logic       pending_nz;
        logic       budget_ok;
        logic       bits_left;
        logic       last_bit;
        logic       bit_push_ok;
        logic       push_ok;
        logic       copy_more;
        logic       flush_ok;
        logic [1:0] evt;
    } lzss_status_t;

endpackage

@@ design/lzss_in_if.sv @@
// ----------------------------------------------------------------------------
// lzss_in_if
// compressed byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lzss_in_if;

    logic                        valid;
    logic                        ready;
    logic [lzss_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

@@ design/lzss_out_if.sv @@
// ----------------------------------------------------------------------------
// lzss_out_if
// decompressed byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lzss_out_if;

    logic                        valid;
    logic                        ready;
    logic [lzss_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_run;
    logic                        end_of_stream;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_stream, output ready);

endinterface

@@ design/lzss_bitstream_decompressor.sv @@
// ----------------------------------------------------------------------------
// lzss_bitstream_decompressor
// lzss decoder with flag bits, 8-bit literals and window position/length
// matches, fed one compressed byte per transaction
// ----------------------------------------------------------------------------
// usage:
//   compressed   - sink channel, one compressed byte per transaction, bits
//                  consumed msb first
//   decompressed - source channel, one decoded byte per transaction;
//                  last_of_run marks the final byte caused by an input byte,
//                  end_of_stream marks the single end transaction
// after reset the history window is swept to zero, one entry per cycle,
// all 2**INDEX_BITS entries (8192 by default), with compressed.ready held low
// each input byte is accepted, then its 8 bits are parsed (one bit a cycle
// while the output can take results), each copied byte gets a registered
// window read, then a write and emit through the single window port, and
// the last result is marked; up to 17 copied bytes can fall in one byte
// a result is held one stage back until the next one (or the end of the
// byte) tells whether it is the last, so it passes the hold register before
// it reaches the output register; the output register takes new data while
// the receiver drains, and when decompressed.ready stays low the parser
// simply waits, nothing is dropped
// once the end marker is decoded, further bytes are taken and ignored
// until the next reset
// ----------------------------------------------------------------------------
module lzss_bitstream_decompressor
#(
    parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
    parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lzss_in_if.sink     compressed,
    lzss_out_if.source  decompressed
);

    lzss_pkg::lzss_cmd_t    cmd;
    lzss_pkg::lzss_status_t st;

    // sequencer
    lzss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .in_ready (compressed.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // parser, window and output stage
    lzss_dp
    #(
        .INDEX_BITS  (INDEX_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .in_byte       (compressed.in_byte),
        .out_valid     (decompressed.valid),
        .out_ready     (decompressed.ready),
        .out_byte      (decompressed.out_byte),
        .last_of_run   (decompressed.last_of_run),
        .end_of_stream (decompressed.end_of_stream)
    );

endmodule

@@ design/lzss_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzss_ctrl
// sequencer: window clear sweep, one bit per cycle while the output takes results, copy read/write pairs
// ----------------------------------------------------------------------------
module lzss_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lzss_pkg::lzss_status_t st,
    output lzss_pkg::lzss_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_BIT     = 3'd2;
    localparam logic [2:0] S_COPY_RD = 3'd3;
    localparam logic [2:0] S_COPY_WR = 3'd4;
    localparam logic [2:0] S_FLUSH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (st.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                // bytes after the end marker are taken and dropped
                if (in_valid && !st.finished)
                begin
                    state_next = st.pending_nz ? S_COPY_RD : S_BIT;
                end
            end
            S_BIT:
            begin
                if (st.bit_push_ok)
                begin
                    cmd.bit_step = 1'b1;
                    if (st.evt == lzss_pkg::EV_ENDMARK)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (st.evt == lzss_pkg::EV_MATCH && st.budget_ok)
                    begin
                        state_next = S_COPY_RD;
                    end
                    else if (st.last_bit)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                if (st.push_ok)
                begin
                    cmd.copy_wr = 1'b1;
                    if (st.copy_more)
                    begin
                        state_next = S_COPY_RD;
                    end
                    else
                    begin
                        state_next = st.bits_left ? S_BIT : S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/lzss_dp.sv @@
// ----------------------------------------------------------------------------
// lzss_dp
// bit parser, history window, copy engine and result hold/output registers
// ----------------------------------------------------------------------------
module lzss_dp
#(
    parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
    parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lzss_pkg::lzss_cmd_t         cmd,
    output lzss_pkg::lzss_status_t      st,
    input  logic [lzss_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lzss_pkg::BYTE_W-1:0] out_byte,
    output logic                        last_of_run,
    output logic                        end_of_stream
);

    localparam int BW         = lzss_pkg::BYTE_W;
    localparam int ACC_W      = (INDEX_BITS > BW) ? INDEX_BITS : BW;
    localparam int REM_W      = $clog2(ACC_W + 1);
    localparam int BREAK_EVEN = (1 + INDEX_BITS + LENGTH_BITS) / lzss_pkg::BREAK_EVEN_DIV;
    localparam int MAX_COPY   = (1 << LENGTH_BITS) + BREAK_EVEN;
    localparam int CP_W       = $clog2(MAX_COPY + 1);
    localparam int WIN_DEPTH  = 1 << INDEX_BITS;
    localparam int NW         = lzss_pkg::RES_CNT_W;
    localparam int BCW        = lzss_pkg::BIT_CNT_W;

    localparam logic [NW-1:0]  MAX_RES = NW'(lzss_pkg::MAX_RESULTS);
    localparam logic [CP_W-1:0] COPY_ADD = CP_W'(1 + BREAK_EVEN);

    // history window
    logic [BW-1:0] win_mem [WIN_DEPTH];
    logic          win_we;
    logic [INDEX_BITS-1:0] win_waddr;
    logic [BW-1:0] win_wdata;
    logic [BW-1:0] rd_data_reg;

    // control state
    logic [BCW-1:0]        bcnt_reg, bcnt_next;
    logic [1:0]            phase_reg, phase_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [INDEX_BITS-1:0] ms_reg, ms_next;
    logic [INDEX_BITS-1:0] wp_reg, wp_next;
    logic [CP_W-1:0]       pend_reg, pend_next;
    logic                  fin_reg, fin_next;
    logic [NW-1:0]         ncnt_reg, ncnt_next;
    logic [INDEX_BITS-1:0] clr_reg, clr_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [BW-1:0] shreg_reg, shreg_next;
    logic [BW-1:0] hold_byte_reg, hold_byte_next;
    logic          hold_eos_reg, hold_eos_next;
    logic [BW-1:0] out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic          out_eos_reg, out_eos_next;

    // bit decode
    logic             cur_bit;
    logic [ACC_W-1:0] acc_sh;
    logic [REM_W-1:0] rem_dec;
    logic [1:0]       evt;
    logic             n_ok;
    logic             out_free;
    logic             push_ok;
    logic [NW-1:0]    n_after;
    logic             push_req;
    logic             push;
    logic [BW-1:0]    push_byte;
    logic             push_eos;
    logic             lit_do;

    assign cur_bit = shreg_reg[BW-1];
    assign acc_sh  = {acc_reg[ACC_W-2:0], cur_bit};
    assign rem_dec = (rem_reg != '0) ? rem_reg - REM_W'(1) : rem_reg;

    always_comb
    begin
        evt = lzss_pkg::EV_NONE;
        if (phase_reg != lzss_pkg::PH_FLAG && rem_dec == '0)
        begin
            case (phase_reg)
                lzss_pkg::PH_LITERAL:  evt = lzss_pkg::EV_LITERAL;
                lzss_pkg::PH_POSITION:
                    evt = (acc_sh[INDEX_BITS-1:0] == '0) ? lzss_pkg::EV_ENDMARK
                                                         : lzss_pkg::EV_NONE;
                lzss_pkg::PH_LENGTH:   evt = lzss_pkg::EV_MATCH;
                default:               evt = lzss_pkg::EV_NONE;
            endcase
        end
    end

    assign n_ok     = ncnt_reg < MAX_RES;
    assign out_free = !out_valid_reg || out_ready;
    assign push_ok  = !n_ok || !hold_valid_reg || out_free;
    assign n_after  = ncnt_reg + NW'(n_ok);
    assign lit_do   = cmd.bit_step && evt == lzss_pkg::EV_LITERAL;

    always_comb
    begin
        st             = '0;
        st.clear_done  = &clr_reg;
        st.finished    = fin_reg;
        st.pending_nz  = pend_reg != '0;
        st.budget_ok   = n_ok;
        st.bits_left   = bcnt_reg != '0;
        st.last_bit    = bcnt_reg == BCW'(1);
        st.push_ok     = push_ok;
        st.bit_push_ok = (evt == lzss_pkg::EV_LITERAL || evt == lzss_pkg::EV_ENDMARK)
                         ? push_ok : 1'b1;
        st.copy_more   = (pend_reg != CP_W'(1)) && (n_after < MAX_RES);
        st.flush_ok    = !hold_valid_reg || out_free;
        st.evt         = evt;
    end

    // result source
    always_comb
    begin
        push_req  = 1'b0;
        push_byte = rd_data_reg;
        push_eos  = 1'b0;
        if (cmd.copy_wr)
        begin
            push_req = 1'b1;
        end
        else if (cmd.bit_step && evt == lzss_pkg::EV_LITERAL)
        begin
            push_req  = 1'b1;
            push_byte = acc_sh[BW-1:0];
        end
        else if (cmd.bit_step && evt == lzss_pkg::EV_ENDMARK)
        begin
            push_req  = 1'b1;
            push_byte = '0;
            push_eos  = 1'b1;
        end
    end
    assign push = push_req && n_ok;

    // window write port
    always_comb
    begin
        win_we    = cmd.clear_en || lit_do || cmd.copy_wr;
        win_waddr = cmd.clear_en ? clr_reg : wp_reg;
        if (cmd.clear_en)
        begin
            win_wdata = '0;
        end
        else if (cmd.copy_wr)
        begin
            win_wdata = rd_data_reg;
        end
        else
        begin
            win_wdata = acc_sh[BW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr] <= win_wdata;
        end
        if (cmd.copy_rd)
        begin
            rd_data_reg <= win_mem[ms_reg];
        end
    end

    // parser and copy state
    always_comb
    begin
        shreg_next = shreg_reg;
        bcnt_next  = bcnt_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        ms_next    = ms_reg;
        wp_next    = wp_reg;
        pend_next  = pend_reg;
        fin_next   = fin_reg;
        ncnt_next  = ncnt_reg;
        clr_next   = clr_reg;

        if (cmd.clear_en)
        begin
            clr_next = clr_reg + INDEX_BITS'(1);
        end

        if (cmd.accept && !fin_reg)
        begin
            shreg_next = in_byte;
            bcnt_next  = BCW'(BW);
            ncnt_next  = '0;
        end

        if (cmd.bit_step)
        begin
            shreg_next = {shreg_reg[BW-2:0], 1'b0};
            bcnt_next  = bcnt_reg - BCW'(1);
            if (phase_reg == lzss_pkg::PH_FLAG)
            begin
                acc_next   = '0;
                phase_next = cur_bit ? lzss_pkg::PH_LITERAL : lzss_pkg::PH_POSITION;
                rem_next   = cur_bit ? REM_W'(BW) : REM_W'(INDEX_BITS);
            end
            else
            begin
                acc_next = acc_sh;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    case (phase_reg)
                        lzss_pkg::PH_LITERAL:
                        begin
                            pend_next  = '0;
                            wp_next    = wp_reg + INDEX_BITS'(1);
                            phase_next = lzss_pkg::PH_FLAG;
                        end
                        lzss_pkg::PH_POSITION:
                        begin
                            acc_next = '0;
                            if (acc_sh[INDEX_BITS-1:0] == '0)
                            begin
                                pend_next  = '0;
                                fin_next   = 1'b1;
                                phase_next = lzss_pkg::PH_FLAG;
                            end
                            else
                            begin
                                ms_next    = acc_sh[INDEX_BITS-1:0];
                                phase_next = lzss_pkg::PH_LENGTH;
                                rem_next   = REM_W'(LENGTH_BITS);
                            end
                        end
                        lzss_pkg::PH_LENGTH:
                        begin
                            pend_next  = CP_W'(acc_sh[LENGTH_BITS-1:0]) + COPY_ADD;
                            phase_next = lzss_pkg::PH_FLAG;
                        end
                        default:
                        begin
                            phase_next = lzss_pkg::PH_FLAG;
                        end
                    endcase
                end
            end
        end

        if (cmd.copy_wr)
        begin
            ms_next   = ms_reg + INDEX_BITS'(1);
            wp_next   = wp_reg + INDEX_BITS'(1);
            pend_next = pend_reg - CP_W'(1);
        end

        if (push)
        begin
            ncnt_next = ncnt_reg + NW'(1);
        end
    end

    // result hold stage and output register
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_eos_next   = hold_eos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_eos_next    = out_eos_reg;

        if ((push || cmd.flush) && hold_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hold_byte_reg;
            out_eos_next   = hold_eos_reg;
            out_last_next  = cmd.flush;
        end
        if (push)
        begin
            hold_valid_next = 1'b1;
            hold_byte_next  = push_byte;
            hold_eos_next   = push_eos;
        end
        else if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg       <= '0;
            phase_reg      <= lzss_pkg::PH_FLAG;
            acc_reg        <= '0;
            rem_reg        <= '0;
            ms_reg         <= '0;
            wp_reg         <= INDEX_BITS'(1);
            pend_reg       <= '0;
            fin_reg        <= 1'b0;
            ncnt_reg       <= '0;
            clr_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bcnt_reg       <= bcnt_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            rem_reg        <= rem_next;
            ms_reg         <= ms_next;
            wp_reg         <= wp_next;
            pend_reg       <= pend_next;
            fin_reg        <= fin_next;
            ncnt_reg       <= ncnt_next;
            clr_reg        <= clr_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg     <= shreg_next;
        hold_byte_reg <= hold_byte_next;
        hold_eos_reg  <= hold_eos_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_eos_reg   <= out_eos_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = out_last_reg;
    assign end_of_stream = out_eos_reg;

endmodule
